FILE: sv/harmonic_mean_filter_3x3_macros.svh
// Assertion macros for the harmonic mean filter.
// Used by the top level; relies on clk and arst_n being in scope at each use.
`ifndef HARMONIC_MEAN_FILTER_3X3_MACROS_SVH
`define HARMONIC_MEAN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define HMF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define HMF_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define HMF_ASSERT(label, prop, msg)
`define HMF_ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: sv/hmf_pkg.sv
// Shared types and constants of the harmonic mean filter.
// No dependencies; imported by every module of the block.
package hmf_pkg;

	// Pixel and window geometry.
	localparam int PIX_W = 8;
	localparam int WIN_N = 9;
	localparam int TAB_N = 1 << PIX_W;

	// Fixed-point format: reciprocals are scaled by 2^24.
	localparam int unsigned RECIP_SCALE = 1 << 24;
	localparam int RECIP_W = 25;
	localparam int SUM_W = 28;
	localparam int QUO_W = 9;
	localparam int DSH_W = SUM_W + QUO_W - 1;
	localparam logic [SUM_W-1:0] DIV_NUM = SUM_W'(WIN_N * RECIP_SCALE);

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int CFG_REG_W = 11;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Result coordinates.
	localparam int OUT_COORD_W = 10;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WIN_N-1:0] win_t;

	// Result of the harmonic mean unit.
	typedef struct packed {
		logic done;
		pix_t value;
	} hmf_res_t;

endpackage

FILE: sv/hmf_line_store.sv
// Two line memories (rows r-2 and r-1) sharing one address, with registered read data.
// Depends on hmf_pkg for the pixel type.
module hmf_line_store #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic                 wr_en,
	input  logic [AW-1:0]        addr,
	input  hmf_pkg::pix_t        wr_upper,
	input  hmf_pkg::pix_t        wr_lower,
	output hmf_pkg::pix_t        rd_upper,
	output hmf_pkg::pix_t        rd_lower
);
	import hmf_pkg::*;

	pix_t upper_mem [DEPTH];
	pix_t lower_mem [DEPTH];
	pix_t rd_upper_q;
	pix_t rd_lower_q;

	// Both rows are written and read at the same column address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[addr] <= wr_upper;
			lower_mem[addr] <= wr_lower;
		end
		if (rd_en) begin
			rd_upper_q <= upper_mem[addr];
			rd_lower_q <= lower_mem[addr];
		end
	end

	assign rd_upper = rd_upper_q;
	assign rd_lower = rd_lower_q;

endmodule

FILE: sv/hmf_hmean.sv
// Harmonic mean of a 3x3 window: serial reciprocal sum, then a restoring divider.
// Depends on hmf_pkg; the window must hold steady from start until done.
module hmf_hmean (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hmf_pkg::win_t     win,
	output hmf_pkg::hmf_res_t res
);
	import hmf_pkg::*;

	localparam logic [1:0] HS_IDLE = 2'd0;
	localparam logic [1:0] HS_SUM  = 2'd1;
	localparam logic [1:0] HS_DIV  = 2'd2;
	localparam logic [3:0] SUM_LAST = 4'(WIN_N - 1);
	localparam logic [3:0] DIV_LAST = 4'(QUO_W - 1);

	logic [RECIP_W-1:0] recip_tab [TAB_N];
	logic [1:0]         hs_q;
	logic [3:0]         step_q;
	logic               done_q;
	logic [SUM_W-1:0]   acc_q;
	logic [SUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	pix_t               val_q;
	logic [SUM_W-1:0]   acc_next;
	logic               fits;
	logic [QUO_W-1:0]   quo_next;

	// Reciprocal table, round(2^24/p) with halves up; a zero pixel never reaches it.
	assign recip_tab[0] = '0;
	for (genvar g = 1; g < TAB_N; g++) begin : g_recip
		localparam int unsigned RV = (RECIP_SCALE + (g / 2)) / g;
		assign recip_tab[g] = RECIP_W'(RV);
	end

	// One reciprocal is added per cycle.
	assign acc_next = acc_q + SUM_W'(recip_tab[win[step_q]]);

	// One quotient bit per cycle, most significant first.
	assign fits = {{(DSH_W - SUM_W){1'b0}}, rem_q} >= dsh_q;
	assign quo_next = {quo_q[QUO_W-2:0], fits};

	// Sequencer of the sum and divide phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HS_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (hs_q)
				HS_IDLE: begin
					step_q <= '0;
					if (start) begin
						hs_q <= HS_SUM;
					end
				end
				HS_SUM: begin
					if (step_q == SUM_LAST) begin
						step_q <= '0;
						hs_q <= HS_DIV;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				HS_DIV: begin
					if (step_q == DIV_LAST) begin
						step_q <= '0;
						done_q <= 1'b1;
						hs_q <= HS_IDLE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				default: begin
					hs_q <= HS_IDLE;
				end
			endcase
		end
	end

	// Datapath: accumulator, remainder, shifted divisor and quotient.
	always_ff @(posedge clk) begin
		case (hs_q)
			HS_IDLE: begin
				acc_q <= '0;
			end
			HS_SUM: begin
				acc_q <= acc_next;
				if (step_q == SUM_LAST) begin
					rem_q <= DIV_NUM;
					dsh_q <= {acc_next, {(QUO_W - 1){1'b0}}};
					quo_q <= '0;
				end
			end
			HS_DIV: begin
				if (fits) begin
					rem_q <= rem_q - dsh_q[SUM_W-1:0];
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				if (step_q == DIV_LAST) begin
					// Saturate a quotient above 255.
					val_q <= quo_next[QUO_W-1] ? '1 : quo_next[PIX_W-1:0];
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign res.done = done_q;
	assign res.value = val_q;

endmodule

FILE: sv/harmonic_mean_filter_3x3.sv
// Streaming 3x3 harmonic mean filter for 8-bit gray frames.
// Channels: pixels enter on in_valid/in_ready in raster order; results leave on
// out_valid/out_ready, each with its pixel value, column, row, run_last (last result
// of the input pixel) and frame_end (bottom-right pixel). Every transfer moves one item.
// Each input pixel gives 0 to 3 results; a pixel is emitted one row and one column
// after it arrives, the right column one row after; the last row is sent on arrival.
// Border pixels are copied; interior pixels get the harmonic mean of their window,
// or zero if the window holds a zero. A pixel whose window is interior and free of
// zeros has its first result in the output register after the line memory read, the
// reciprocal sum and the divider; any other pixel with a result loads it after the read.
// Further results of the same pixel follow one per cycle while the receiver is ready.
// One pixel is in work at a time; the next pixel is taken once the last result sits
// in the output register, so a stalled receiver holds only that one.
// Configuration: image_width at byte address 0 and image_height at 4 over the APB
// port; a write restarts the frame. Reset sets 640 x 480, clears the counts and window.
// Line memory contents are not cleared; no result reads an entry not yet written.
// Depends on hmf_pkg, hmf_line_store, hmf_hmean and the assertion macro header.
`include "harmonic_mean_filter_3x3_macros.svh"

module harmonic_mean_filter_3x3 #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [hmf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [hmf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [hmf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  hmf_pkg::pix_t                      pixel_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output hmf_pkg::pix_t                      pixel_out,
	output logic [hmf_pkg::OUT_COORD_W-1:0]    out_column,
	output logic [hmf_pkg::OUT_COORD_W-1:0]    out_row,
	output logic                               run_last,
	output logic                               frame_end
);
	import hmf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// Result slots of one input pixel, in emission order.
	localparam logic [2:0] SLOT_PREV = 3'b001;
	localparam logic [2:0] SLOT_EDGE = 3'b010;
	localparam logic [2:0] SLOT_LAST = 3'b100;

	// Control state.
	logic [1:0]        state_q;
	logic [WW-1:0]     width_q;
	logic [HW-1:0]     height_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	pix_t              wc_q [6];
	logic [2:0]        pend_q;
	logic              out_valid_q;

	// Per-pixel payload.
	pix_t              pix_s1;
	logic [CW-1:0]     col_s1;
	logic [RW-1:0]     row_s1;
	win_t              win_s2;
	pix_t              mid_s2;
	logic              last_col_s2;
	pix_t              val0_q;
	pix_t              pixel_out_q;
	logic [OUT_COORD_W-1:0] out_column_q;
	logic [OUT_COORD_W-1:0] out_row_q;
	logic              run_last_q;
	logic              frame_end_q;

	// Combinational signals.
	logic              in_xfer;
	logic              cfg_wr;
	logic [31:0]       cfg_val;
	logic [WW-1:0]     width_new;
	logic [HW-1:0]     height_new;
	pix_t              rd_upper;
	pix_t              rd_lower;
	win_t              win_now;
	logic              any_zero;
	logic              at_last_col;
	logic              at_last_row;
	logic              has_prev;
	logic              inner_prev;
	logic              has_edge;
	logic              need_calc;
	logic              adv_last_col;
	logic              adv_last_row;
	logic              out_load;
	logic [2:0]        sel;
	logic [2:0]        remaining;
	logic [CW-1:0]     col_m1;
	logic [RW-1:0]     row_m1;
	hmf_res_t          hm_res;

	assign in_xfer = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign pready = 1'b1;

	// Register write decode and clamping of size values to 1..MAX.
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_val = 32'(pwdata[CFG_REG_W-1:0]);

	always_comb begin
		if (cfg_val == 32'd0) begin
			width_new = WW'(1);
			height_new = HW'(1);
		end else begin
			width_new = (cfg_val > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_val);
			height_new = (cfg_val > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_val);
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1] == REG_HEIGHT) ? APB_DATA_W'(height_q)
	                                                    : APB_DATA_W'(width_q);

	// Line memories, addressed by the current column.
	hmf_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.rd_en    (in_xfer),
		.wr_en    (state_q == ST_READ),
		.addr     (col_q),
		.wr_upper (rd_lower),
		.wr_lower (pix_s1),
		.rd_upper (rd_upper),
		.rd_lower (rd_lower)
	);

	// Window around the pixel one row and one column back.
	assign win_now = {pix_s1, wc_q[5], wc_q[4], rd_lower, wc_q[3], wc_q[2],
	                  rd_upper, wc_q[1], wc_q[0]};

	always_comb begin
		any_zero = 1'b0;
		for (int i = 0; i < WIN_N; i++) begin
			any_zero = any_zero || (win_now[i] == '0);
		end
	end

	// Which results this pixel produces.
	assign at_last_col = (WW'(col_s1) == width_q - WW'(1));
	assign at_last_row = (HW'(row_s1) == height_q - HW'(1));
	assign has_prev = (row_s1 != '0) && (col_s1 != '0);
	assign inner_prev = (row_s1 > RW'(1)) && (col_s1 > CW'(1));
	assign has_edge = (row_s1 != '0) && at_last_col;
	assign need_calc = inner_prev && !any_zero;

	// Raster position advance, evaluated on the live counts.
	assign adv_last_col = (WW'(col_q) == width_q - WW'(1));
	assign adv_last_row = (HW'(row_q) == height_q - HW'(1));

	hmf_hmean u_hmean (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == ST_READ) && need_calc),
		.win    (win_s2),
		.res    (hm_res)
	);

	// Output register loads the lowest pending slot.
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign sel = pend_q & (~pend_q + 3'd1);
	assign remaining = pend_q & ~sel;
	assign col_m1 = col_s1 - CW'(1);
	assign row_m1 = row_s1 - RW'(1);

	// Control state, counts, window columns and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= WW'(W_RST);
			height_q <= HW'(H_RST);
			col_q <= '0;
			row_q <= '0;
			pend_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				wc_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				if (paddr[APB_ADDR_W-1] == REG_WIDTH) begin
					width_q <= width_new;
				end else begin
					height_q <= height_new;
				end
				col_q <= '0;
				row_q <= '0;
				for (int i = 0; i < 6; i++) begin
					wc_q[i] <= '0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					pend_q <= {at_last_row, has_edge, has_prev};
					if (need_calc) begin
						state_q <= ST_CALC;
					end else if (has_prev || has_edge || at_last_row) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
					wc_q[0] <= wc_q[1];
					wc_q[1] <= rd_upper;
					wc_q[2] <= wc_q[3];
					wc_q[3] <= rd_lower;
					wc_q[4] <= wc_q[5];
					wc_q[5] <= pix_s1;
					if (adv_last_col) begin
						col_q <= '0;
						row_q <= adv_last_row ? '0 : row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_CALC: begin
					if (hm_res.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						pend_q <= remaining;
						if (remaining == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the pixel in work and of the output.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1 <= pixel_in;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		if (state_q == ST_READ) begin
			win_s2 <= win_now;
			mid_s2 <= rd_lower;
			last_col_s2 <= at_last_col;
			// A border neighbor is copied; a zero in an interior window gives zero.
			val0_q <= inner_prev ? '0 : wc_q[3];
		end
		if ((state_q == ST_CALC) && hm_res.done) begin
			val0_q <= hm_res.value;
		end
		if (out_load) begin
			run_last_q <= (remaining == '0);
			case (sel)
				SLOT_PREV: begin
					pixel_out_q <= val0_q;
					out_column_q <= OUT_COORD_W'(col_m1);
					out_row_q <= OUT_COORD_W'(row_m1);
					frame_end_q <= 1'b0;
				end
				SLOT_EDGE: begin
					pixel_out_q <= mid_s2;
					out_column_q <= OUT_COORD_W'(col_s1);
					out_row_q <= OUT_COORD_W'(row_m1);
					frame_end_q <= 1'b0;
				end
				SLOT_LAST: begin
					pixel_out_q <= pix_s1;
					out_column_q <= OUT_COORD_W'(col_s1);
					out_row_q <= OUT_COORD_W'(row_s1);
					frame_end_q <= last_col_s2;
				end
				default: begin
					pixel_out_q <= pix_s1;
					out_column_q <= OUT_COORD_W'(col_s1);
					out_row_q <= OUT_COORD_W'(row_s1);
					frame_end_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign out_column = out_column_q;
	assign out_row = out_row_q;
	assign run_last = run_last_q;
	assign frame_end = frame_end_q;

	// Consistency checks.
	`HMF_ASSERT(a_col_in_range, (WW'(col_q) < width_q), "column count reached the width")
	`HMF_ASSERT(a_idle_no_pending, (state_q == ST_IDLE) |-> (pend_q == 3'b000), "idle with pending results")
	`HMF_ASSERT_NEVER(a_done_in_calc, hm_res.done && (state_q != ST_CALC), "mean ready outside calc")
	`HMF_ASSERT(a_frame_end_last, (out_valid_q && frame_end_q) |-> run_last_q, "frame end not last result")

endmodule

FILE: tb/sv/harmonic_mean_filter_3x3_test.sv
// Self-checking testbench for the streaming 3x3 harmonic mean filter.
// A bit-exact predictor checks every result; sizes are set over the APB port.
// Depends on hmf_pkg and the harmonic_mean_filter_3x3 top level.
module harmonic_mean_filter_3x3_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hmf_pkg::*;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_STALL = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS = 20;

	typedef enum {NO_IDLE, SENDER_IDLE, RECEIVER_STALL, BOTH_IDLE} idle_mode_t;

	// One emitted pixel as the block should present it.
	typedef struct {
		pix_t pixel;
		logic [OUT_COORD_W-1:0] column;
		logic [OUT_COORD_W-1:0] row;
		logic run_last;
		logic frame_end;
	} filtered_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	pix_t pixel_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_t pixel_out;
	logic [OUT_COORD_W-1:0] out_column;
	logic [OUT_COORD_W-1:0] out_row;
	logic run_last;
	logic frame_end;

	// Stimulus and scoreboard state.
	pix_t pixel_queue[$];
	filtered_pixel_t expected_pixels[$];
	idle_mode_t idle_mode = NO_IDLE;
	logic pixel_taken = 1'b0;
	logic long_stall_req = 1'b0;
	int stall_left = 0;
	int error_count = 0;
	int reg_errors = 0;
	int pixels_accepted = 0;
	int results_checked = 0;
	int frames_seen = 0;
	int random_sent = 0;
	int idle_cycles = 0;

	// Predictor state: two line stores, the window columns, position and size.
	pix_t line_older[MAX_COLS];
	pix_t line_newer[MAX_COLS];
	pix_t win_cols[6];
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned frame_width;
	int unsigned frame_height;

	harmonic_mean_filter_3x3 #(
		.MAX_WIDTH(MAX_COLS),
		.MAX_HEIGHT(MAX_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_out(pixel_out),
		.out_column(out_column),
		.out_row(out_row),
		.run_last(run_last),
		.frame_end(frame_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Harmonic mean of nine pixels with reciprocals scaled by 2^24.
	function automatic pix_t harmonic_of(input pix_t w[9]);
		int unsigned sum;
		int unsigned q;
		sum = 0;
		foreach (w[i]) begin
			if (w[i] == 8'd0)
				return 8'd0;
			sum += ((32'd1 << 24) + (w[i] >> 1)) / w[i];
		end
		q = (32'd9 << 24) / sum;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	function automatic int unsigned clamp_size(input logic [APB_DATA_W-1:0] data, input int limit);
		int unsigned v;
		v = data[CFG_REG_W-1:0];
		if (v < 1)
			v = 1;
		if (v > limit)
			v = limit;
		return v;
	endfunction

	// A size write restarts the frame.
	function void apply_size(input logic reg_idx, input logic [APB_DATA_W-1:0] data);
		if (reg_idx == REG_WIDTH)
			frame_width = clamp_size(data, MAX_COLS);
		else
			frame_height = clamp_size(data, MAX_ROWS);
		col_pos = 0;
		row_pos = 0;
		foreach (win_cols[i])
			win_cols[i] = '0;
	endfunction

	function void add_expected(input pix_t value, input int unsigned x, input int unsigned y,
			input logic fend);
		filtered_pixel_t res;
		res.pixel = value;
		res.column = x[OUT_COORD_W-1:0];
		res.row = y[OUT_COORD_W-1:0];
		res.run_last = 1'b0;
		res.frame_end = fend;
		expected_pixels.push_back(res);
	endfunction

	// Works out the results that one accepted pixel causes and advances the window.
	function void predict_pixel(input pix_t p);
		int unsigned c;
		int unsigned r;
		int queued;
		pix_t top;
		pix_t mid;
		pix_t v;
		pix_t win[9];
		c = col_pos;
		r = row_pos;
		if (c >= frame_width || c >= MAX_COLS)
			c = 0;
		if (r >= frame_height)
			r = 0;
		top = line_older[c];
		mid = line_newer[c];
		queued = expected_pixels.size();
		if (r >= 1) begin
			// The pixel one row up and one column left is now complete.
			if (c >= 1) begin
				if (c == 1 || r == 1) begin
					v = win_cols[3];
				end else begin
					win = '{win_cols[0], win_cols[1], top, win_cols[2], win_cols[3], mid,
						win_cols[4], win_cols[5], p};
					v = harmonic_of(win);
				end
				add_expected(v, c - 1, r - 1, 1'b0);
			end
			// Right border pixel of the row above.
			if (c == frame_width - 1)
				add_expected(mid, c, r - 1, 1'b0);
		end
		// The last row is copied out as it arrives.
		if (r == frame_height - 1)
			add_expected(p, c, r, c == frame_width - 1);
		if (expected_pixels.size() > queued)
			expected_pixels[expected_pixels.size() - 1].run_last = 1'b1;
		win_cols[0] = win_cols[1];
		win_cols[1] = top;
		win_cols[2] = win_cols[3];
		win_cols[3] = mid;
		win_cols[4] = win_cols[5];
		win_cols[5] = p;
		line_older[c] = mid;
		line_newer[c] = p;
		c++;
		if (c >= frame_width) begin
			c = 0;
			r++;
			if (r >= frame_height)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	function automatic bit chance(input int percent);
		return $urandom_range(0, 99) < percent;
	endfunction

	function automatic pix_t random_pixel();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return 8'd0;
		if (pick < 8)
			return 8'd255;
		if (pick < 10)
			return 8'd1;
		return pix_t'($urandom_range(1, 255));
	endfunction

	// Sender: presents the next pixel at the falling edge once the last one moved.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || pixel_taken)) begin
			if (pixel_queue.size() > 0 &&
					!((idle_mode == SENDER_IDLE && chance(56)) ||
					(idle_mode == BOTH_IDLE && chance(17)))) begin
				pixel_in <= pixel_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		pixel_taken = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (long_stall_req) begin
			stall_left = LONG_STALL;
			long_stall_req = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !((idle_mode == RECEIVER_STALL && chance(56)) ||
				(idle_mode == BOTH_IDLE && chance(17)));
		end
	end

	// Monitor: predicts on each input transfer and checks each output transfer.
	always @(posedge clk) begin
		filtered_pixel_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_pixel(pixel_in);
				pixel_taken = 1'b1;
				pixels_accepted++;
			end
			if (out_valid && out_ready) begin
				results_checked++;
				if (frame_end)
					frames_seen++;
				if (expected_pixels.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected result pixel %0d at (%0d,%0d)", $realtime,
							pixel_out, out_column, out_row);
				end else begin
					want = expected_pixels.pop_front();
					if (pixel_out !== want.pixel || out_column !== want.column ||
							out_row !== want.row || run_last !== want.run_last ||
							frame_end !== want.frame_end) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("%0t: mismatch: expected pixel %0d (%0d,%0d) last %0b end %0b,",
								$realtime, want.pixel, want.column, want.row, want.run_last,
								want.frame_end, " got pixel %0d (%0d,%0d) last %0b end %0b",
								pixel_out, out_column, out_row, run_last, frame_end);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $realtime,
				idle_cycles, expected_pixels.size());
			$display("harmonic_mean_filter_3x3 regression: fail");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle; the register takes it at the edge.
	task automatic write_register(input logic reg_idx, input logic [APB_DATA_W-1:0] data);
		int unsigned want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		apply_size(reg_idx, data);
		@(negedge clk);
		// The register reads back the clamped size.
		want = (reg_idx == REG_WIDTH) ? frame_width : frame_height;
		if (prdata !== APB_DATA_W'(want) || pready !== 1'b1) begin
			reg_errors++;
			$display("%0t: register %0d: expected %0d ready 1, got %0d ready %0b", $realtime,
				reg_idx, want, prdata, pready);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every queued pixel is in and every expected result is out.
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_frames(input logic [APB_DATA_W-1:0] width_word,
			input logic [APB_DATA_W-1:0] height_word, input int pixel_count,
			input idle_mode_t mode, input bit hold_receiver);
		idle_mode = mode;
		write_register(REG_WIDTH, width_word);
		write_register(REG_HEIGHT, height_word);
		if (hold_receiver)
			long_stall_req = 1'b1;
		repeat (pixel_count) pixel_queue.push_back(random_pixel());
		random_sent += pixel_count;
		wait_for_drain();
	endtask

	initial begin
		int w;
		int h;
		foreach (line_older[i]) begin
			line_older[i] = '0;
			line_newer[i] = '0;
		end
		foreach (win_cols[i])
			win_cols[i] = '0;
		frame_width = 640;
		frame_height = 480;
		col_pos = 0;
		row_pos = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A few pixels at the reset size give no results; the next write restarts.
		pixel_queue = '{8'd0, 8'd255, 8'd77};
		wait_for_drain();

		// Directed 4x4 frame: an all-255 window, a zero in the window, 1s in the last row.
		idle_mode = NO_IDLE;
		write_register(REG_WIDTH, 32'd4);
		write_register(REG_HEIGHT, 32'd4);
		pixel_queue = '{8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd255, 8'd0,
			8'd1, 8'd1, 8'd1, 8'd1};
		wait_for_drain();

		// Random content over a range of sizes, idling mixes and wrap-arounds.
		run_frames(32'd5, 32'd4, 40, NO_IDLE, 1'b0);
		run_frames(32'd3, 32'd3, 27, SENDER_IDLE, 1'b0);
		run_frames(32'd0, 32'd7, 14, RECEIVER_STALL, 1'b0);
		run_frames(32'd8, 32'd1, 16, BOTH_IDLE, 1'b0);
		run_frames(32'd6, 32'd5, 17, SENDER_IDLE, 1'b0);
		run_frames(32'd2, 32'd2, 12, BOTH_IDLE, 1'b0);
		run_frames(32'd16, 32'd6, 64, NO_IDLE, 1'b1);
		run_frames(32'hFFFF_F807, 32'd3, 42, RECEIVER_STALL, 1'b0);
		run_frames(32'd4, 32'd9, 36, idle_mode_t'($urandom_range(0, 3)), 1'b0);
		run_frames(32'd1, 32'd1, 3, SENDER_IDLE, 1'b0);
		while (random_sent < 290) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			run_frames(w, h, w * h + $urandom_range(0, w),
				idle_mode_t'($urandom_range(0, 3)), 1'b0);
		end

		// Largest sizes: the start of a full-width row and of a full-height column.
		run_frames(32'd2047, 32'd1, 24, NO_IDLE, 1'b0);
		run_frames(32'd1, 32'd1500, 16, BOTH_IDLE, 1'b0);

		$display("Pixels in: %0d, results checked: %0d, frames completed: %0d.",
			pixels_accepted, results_checked, frames_seen);
		$display("Sizes from 1x1 up to the 1024 x 1024 limit, clamped writes, all idling mixes.");
		if (error_count == 0 && reg_errors == 0)
			$display("harmonic_mean_filter_3x3 regression: pass");
		else
			$display("harmonic_mean_filter_3x3 regression: fail");
		$finish;
	end

endmodule
